[hdl/assert_macros.svh]
// assertion helpers used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check on clk_i, held off while rst_ni is low
`define CFE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cfe assertion failed");

// same check with a message of its own
`define CFE_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

[hdl/cfe_pkg.sv]
package cfe_pkg;

  localparam int MAX_DIM     = 128;
  localparam int SAMPLE_BITS = 16;
  localparam int PLANE_SIZE  = (MAX_DIM + 1) * (MAX_DIM + 1);
  localparam int ADDR_W      = $clog2(PLANE_SIZE);
  localparam int IDX_W       = 22;
  localparam int EPOCH_W     = 8;
  localparam int DIM_W       = 8;
  localparam int COORD_W     = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ENTRY_W     = EPOCH_W + IDX_W;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_X     = 3'd0,
    CFG_DIM_Y     = 3'd1,
    CFG_DIM_Z     = 3'd2,
    CFG_THRESHOLD = 3'd3,
    CFG_INVERT    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR_RST,
    ST_IDLE,
    ST_PREP,
    ST_CLEAR_VOX,
    ST_FACE,
    ST_READ,
    ST_CHECK,
    ST_TRI_A,
    ST_TRI_B
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic capture;
    logic plane_update;
    logic clr_step;
    logic next_face;
    logic rd_issue;
    logic corner_commit;
    logic emit_tri_a;
    logic emit_tri_b;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic active;
    logic sweep_needed;
    logic clr_last;
    logic face_open;
    logic last_face;
    logic last_corner;
    logic hit;
    logic out_free;
  } status_t;

  // corner offsets {dx, dy, dz}, faces +z -z +x -x +y -y
  function automatic logic [2:0] face_corner(logic [2:0] face, logic [1:0] corner);
    logic [11:0] row;
    unique case (face)
      3'd0:    row = {3'b001, 3'b101, 3'b111, 3'b011};
      3'd1:    row = {3'b000, 3'b010, 3'b110, 3'b100};
      3'd2:    row = {3'b100, 3'b110, 3'b111, 3'b101};
      3'd3:    row = {3'b000, 3'b001, 3'b011, 3'b010};
      3'd4:    row = {3'b010, 3'b011, 3'b111, 3'b110};
      3'd5:    row = {3'b000, 3'b100, 3'b101, 3'b001};
      default: row = '0;
    endcase
    return row[3*(3-corner) +: 3];
  endfunction

  // zero reads as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

[hdl/cfe_plane_ram.sv]
module cfe_plane_ram #(
  parameter int DEPTH = 16641,
  parameter int WIDTH = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/cfe_ctrl.sv]
module cfe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  cfe_pkg::status_t status_i,
  output cfe_pkg::cmd_t    cmd_o
);
  import cfe_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR_RST;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR_RST: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        if (!status_i.in_range) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.plane_update = 1'b1;
          state_d = status_i.sweep_needed ? ST_CLEAR_VOX : ST_FACE;
        end
      end
      ST_CLEAR_VOX: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = ST_FACE;
      end
      ST_FACE: begin
        if (!status_i.active) begin
          state_d = ST_IDLE;
        end else if (status_i.face_open) begin
          state_d = ST_READ;
        end else begin
          cmd_o.next_face = 1'b1;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.hit || status_i.out_free) begin
          cmd_o.corner_commit = 1'b1;
          state_d = status_i.last_corner ? ST_TRI_A : ST_READ;
        end
      end
      ST_TRI_A: begin
        if (status_i.out_free) begin
          cmd_o.emit_tri_a = 1'b1;
          state_d          = ST_TRI_B;
        end
      end
      ST_TRI_B: begin
        if (status_i.out_free) begin
          cmd_o.emit_tri_b = 1'b1;
          if (status_i.last_face) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_face = 1'b1;
            state_d         = ST_FACE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hdl/cfe_datapath.sv]
`include "assert_macros.svh"

module cfe_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfe_pkg::cmd_t                   cmd_i,
  output cfe_pkg::status_t                status_o,
  input  logic                            cfg_valid_i,
  input  logic [cfe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cfe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [cfe_pkg::COORD_W-1:0]     voxel_x_i,
  input  logic [cfe_pkg::COORD_W-1:0]     voxel_y_i,
  input  logic [cfe_pkg::COORD_W-1:0]     voxel_z_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] center_sample_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_xm_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_ym_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_zm_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_xp_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_yp_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_zp_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic                            item_kind_o,
  output logic [cfe_pkg::DIM_W-1:0]       corner_x_o,
  output logic [cfe_pkg::DIM_W-1:0]       corner_y_o,
  output logic [cfe_pkg::DIM_W-1:0]       corner_z_o,
  output logic [cfe_pkg::IDX_W-1:0]       new_index_o,
  output logic [cfe_pkg::IDX_W-1:0]       tri_first_o,
  output logic [cfe_pkg::IDX_W-1:0]       tri_second_o,
  output logic [cfe_pkg::IDX_W-1:0]       tri_third_o,
  output logic                            last_of_voxel_o
);
  import cfe_pkg::*;

  // configuration registers
  logic [DIM_W-1:0]       dim_x_q, dim_y_q, dim_z_q;
  logic [SAMPLE_BITS-1:0] thr_q;
  logic                   inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DIM_W'(MAX_DIM);
      dim_y_q <= DIM_W'(MAX_DIM);
      dim_z_q <= DIM_W'(MAX_DIM);
      thr_q   <= SAMPLE_BITS'(32768);
      inv_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_DIM_X:     dim_x_q <= cfg_data_i[DIM_W-1:0];
        CFG_DIM_Y:     dim_y_q <= cfg_data_i[DIM_W-1:0];
        CFG_DIM_Z:     dim_z_q <= cfg_data_i[DIM_W-1:0];
        CFG_THRESHOLD: thr_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_INVERT:    inv_q   <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  function automatic logic is_in(logic [SAMPLE_BITS-1:0] s, logic [SAMPLE_BITS-1:0] t,
                                 logic inv);
    return (s >= t) ^ inv;
  endfunction

  // classification of the incoming voxel
  logic [DIM_W-1:0] dx, dy, dz;
  logic [DIM_W-1:0] vx, vy, vz;
  logic             in_range_c, vol_start_c;
  logic [5:0]       open_c;

  always_comb begin
    dx = eff_dim(dim_x_q);
    dy = eff_dim(dim_y_q);
    dz = eff_dim(dim_z_q);
    vx = DIM_W'(voxel_x_i);
    vy = DIM_W'(voxel_y_i);
    vz = DIM_W'(voxel_z_i);
    in_range_c  = (vx < dx) && (vy < dy) && (vz < dz);
    vol_start_c = (vx == '0) && (vy == '0) && (vz == '0);
    open_c[0] = !((vz + DIM_W'(1) < dz) && is_in(sample_zp_i, thr_q, inv_q));
    open_c[1] = !((vz != '0) && is_in(sample_zm_i, thr_q, inv_q));
    open_c[2] = !((vx + DIM_W'(1) < dx) && is_in(sample_xp_i, thr_q, inv_q));
    open_c[3] = !((vx != '0) && is_in(sample_xm_i, thr_q, inv_q));
    open_c[4] = !((vy + DIM_W'(1) < dy) && is_in(sample_yp_i, thr_q, inv_q));
    open_c[5] = !((vy != '0) && is_in(sample_ym_i, thr_q, inv_q));
  end

  logic [COORD_W-1:0] x_q, y_q, z_q;
  logic               in_range_q, vol_start_q, inside_q;
  logic [5:0]         open_q;

  // capture of the accepted voxel
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q         <= voxel_x_i;
      y_q         <= voxel_y_i;
      z_q         <= voxel_z_i;
      in_range_q  <= in_range_c;
      vol_start_q <= vol_start_c;
      inside_q    <= is_in(center_sample_i, thr_q, inv_q);
      open_q      <= open_c;
    end
  end

  // plane bookkeeping: bank roles, epochs, sweep mask
  logic [COORD_W-1:0] plane_q;
  logic               seen_q, up_sel_q;
  logic [EPOCH_W-1:0] ep_q [2];
  logic [1:0]         mask_q;
  logic [ADDR_W-1:0]  clr_addr_q;
  logic [IDX_W-1:0]   vcnt_q;
  logic [1:0]         need_new, at_max;
  logic               rotate;
  logic               clr_last;

  always_comb begin
    rotate = !seen_q || (z_q != plane_q);
    if (vol_start_q) begin
      need_new = 2'b11;
    end else if (rotate) begin
      need_new = up_sel_q ? 2'b01 : 2'b10;
    end else begin
      need_new = 2'b00;
    end
    at_max   = {ep_q[1] == EPOCH_MAX, ep_q[0] == EPOCH_MAX};
    clr_last = (clr_addr_q == ADDR_W'(PLANE_SIZE - 1));
  end

  // corner sequencing and lookup
  logic [2:0]        face_q;
  logic [1:0]        corner_q;
  logic [2:0]        off;
  logic [DIM_W-1:0]  cx, cy, cz;
  logic [ADDR_W-1:0] addr_c;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              rd_bank_q;
  logic [DIM_W-1:0]  cx_q, cy_q, cz_q;
  logic [IDX_W-1:0]  v_q [4];
  logic [ENTRY_W-1:0] rdata [2];
  logic [ENTRY_W-1:0] rsel;
  logic               hit;
  logic               out_free, emit_vtx;
  logic [5:0]         later;

  always_comb begin
    off    = face_corner(face_q, corner_q);
    cx     = DIM_W'(x_q) + DIM_W'(off[2]);
    cy     = DIM_W'(y_q) + DIM_W'(off[1]);
    cz     = DIM_W'(z_q) + DIM_W'(off[0]);
    addr_c = ADDR_W'(cx) + ADDR_W'(cy) * ADDR_W'(MAX_DIM + 1);
    rsel   = rdata[rd_bank_q];
    hit    = (rsel[ENTRY_W-1:IDX_W] == ep_q[rd_bank_q]);
    out_free = !out_valid_o || !out_stall_i;
    emit_vtx = cmd_i.corner_commit && !hit;
    later    = (open_q >> face_q) >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q    <= '0;
      seen_q     <= 1'b0;
      up_sel_q   <= 1'b0;
      ep_q[0]    <= '0;
      ep_q[1]    <= '0;
      mask_q     <= 2'b11;
      clr_addr_q <= '0;
      vcnt_q     <= '0;
      face_q     <= '0;
      corner_q   <= '0;
    end else begin
      if (cmd_i.plane_update) begin
        for (int b = 0; b < 2; b++) begin
          if (need_new[b]) begin
            if (at_max[b]) mask_q[b] <= 1'b1;
            else ep_q[b] <= ep_q[b] + EPOCH_W'(1);
          end
        end
        seen_q <= 1'b1;
        if (vol_start_q) begin
          vcnt_q  <= '0;
          plane_q <= '0;
        end else if (rotate) begin
          up_sel_q <= !up_sel_q;
          plane_q  <= z_q;
        end
      end
      // sweep resets tags; a swept bank restarts at epoch one
      if (cmd_i.clr_step) begin
        if (clr_last) begin
          clr_addr_q <= '0;
          for (int b = 0; b < 2; b++) begin
            if (mask_q[b]) ep_q[b] <= EPOCH_W'(1);
          end
          mask_q <= 2'b00;
        end else begin
          clr_addr_q <= clr_addr_q + ADDR_W'(1);
        end
      end
      if (cmd_i.capture) begin
        face_q   <= '0;
        corner_q <= '0;
      end else if (cmd_i.next_face) begin
        face_q   <= face_q + 3'd1;
        corner_q <= '0;
      end else if (cmd_i.corner_commit) begin
        corner_q <= corner_q + 2'd1;
      end
      if (emit_vtx) vcnt_q <= vcnt_q + IDX_W'(1);
    end
  end

  // read issue and corner results
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_addr_q <= addr_c;
      rd_bank_q <= off[0] ? up_sel_q : !up_sel_q;
      cx_q      <= cx;
      cy_q      <= cy;
      cz_q      <= cz;
    end
    if (cmd_i.corner_commit) begin
      v_q[corner_q] <= hit ? rsel[IDX_W-1:0] : vcnt_q;
    end
  end

  // plane banks
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    always_comb begin
      we    = (cmd_i.clr_step && mask_q[b]) || (emit_vtx && (rd_bank_q == 1'(b)));
      waddr = cmd_i.clr_step ? clr_addr_q : rd_addr_q;
      wdata = cmd_i.clr_step ? '0 : {ep_q[b], vcnt_q};
    end
    cfe_plane_ram #(
      .DEPTH(PLANE_SIZE),
      .WIDTH(ENTRY_W)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .raddr_i(addr_c),
      .rdata_o(rdata[b])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit_vtx || cmd_i.emit_tri_a || cmd_i.emit_tri_b) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_vtx) begin
      item_kind_o     <= 1'b0;
      corner_x_o      <= cx_q;
      corner_y_o      <= cy_q;
      corner_z_o      <= cz_q;
      new_index_o     <= vcnt_q;
      tri_first_o     <= '0;
      tri_second_o    <= '0;
      tri_third_o     <= '0;
      last_of_voxel_o <= 1'b0;
    end else if (cmd_i.emit_tri_a || cmd_i.emit_tri_b) begin
      item_kind_o     <= 1'b1;
      corner_x_o      <= '0;
      corner_y_o      <= '0;
      corner_z_o      <= '0;
      new_index_o     <= '0;
      tri_first_o     <= v_q[0];
      tri_second_o    <= cmd_i.emit_tri_a ? v_q[1] : v_q[2];
      tri_third_o     <= cmd_i.emit_tri_a ? v_q[2] : v_q[3];
      last_of_voxel_o <= cmd_i.emit_tri_b && (later == '0);
    end
  end

  // status to the controller
  always_comb begin
    status_o.in_range     = in_range_q;
    status_o.active       = inside_q && (open_q != '0);
    status_o.sweep_needed = (need_new & at_max) != 2'b00;
    status_o.clr_last     = clr_last;
    status_o.face_open    = open_q[face_q];
    status_o.last_face    = (later == '0);
    status_o.last_corner  = (corner_q == 2'd3);
    status_o.hit          = hit;
    status_o.out_free     = out_free;
  end

  `CFE_ASSERT_MSG(a_emit_no_overwrite,
    (emit_vtx || cmd_i.emit_tri_a || cmd_i.emit_tri_b) && out_valid_o |-> !out_stall_i,
    "result emitted over a pending one")
  `CFE_ASSERT(a_sweep_has_bank, cmd_i.clr_step |-> (mask_q != 2'b00))
  `CFE_ASSERT(a_volume_restart, cmd_i.plane_update && vol_start_q |=> (vcnt_q == '0))

endmodule

[hdl/cuberille_face_extractor_unit.sv]
// channel  direction  handshake        payload
// in       input      valid / stall    voxel coordinates, center and six neighbor samples
// out      output     valid / stall    vertex or triangle record, last_of_voxel
// cfg      input      valid / ready    register index, write data
//
// a voxel is captured and classified, then each open face is scanned; per corner the
// plane memory is read then the corner committed, and each face emits two triangles
// after reset a pass clearing 16641 plane entries runs before the first voxel is taken
// the same pass runs for a plane bank each time its 8 bit epoch counter wraps
// an output stall holds the sequencer at the next record; cfg is always ready
module cuberille_face_extractor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [cfe_pkg::COORD_W-1:0]     voxel_x_i,
  input  logic [cfe_pkg::COORD_W-1:0]     voxel_y_i,
  input  logic [cfe_pkg::COORD_W-1:0]     voxel_z_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] center_sample_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_xm_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_ym_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_zm_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_xp_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_yp_i,
  input  logic [cfe_pkg::SAMPLE_BITS-1:0] sample_zp_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            item_kind_o,
  output logic [cfe_pkg::DIM_W-1:0]       corner_x_o,
  output logic [cfe_pkg::DIM_W-1:0]       corner_y_o,
  output logic [cfe_pkg::DIM_W-1:0]       corner_z_o,
  output logic [cfe_pkg::IDX_W-1:0]       new_index_o,
  output logic [cfe_pkg::IDX_W-1:0]       tri_first_o,
  output logic [cfe_pkg::IDX_W-1:0]       tri_second_o,
  output logic [cfe_pkg::IDX_W-1:0]       tri_third_o,
  output logic                            last_of_voxel_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cfe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cfe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import cfe_pkg::*;

  cmd_t    cmd;
  status_t status;

  // handshake glue
  assign in_stall_o  = !cmd.idle;
  assign cfg_ready_o = 1'b1;

  cfe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  cfe_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .voxel_x_i      (voxel_x_i),
    .voxel_y_i      (voxel_y_i),
    .voxel_z_i      (voxel_z_i),
    .center_sample_i(center_sample_i),
    .sample_xm_i    (sample_xm_i),
    .sample_ym_i    (sample_ym_i),
    .sample_zm_i    (sample_zm_i),
    .sample_xp_i    (sample_xp_i),
    .sample_yp_i    (sample_yp_i),
    .sample_zp_i    (sample_zp_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .item_kind_o    (item_kind_o),
    .corner_x_o     (corner_x_o),
    .corner_y_o     (corner_y_o),
    .corner_z_o     (corner_z_o),
    .new_index_o    (new_index_o),
    .tri_first_o    (tri_first_o),
    .tri_second_o   (tri_second_o),
    .tri_third_o    (tri_third_o),
    .last_of_voxel_o(last_of_voxel_o)
  );

endmodule
